>>> hw/rtl/rssm_pkg.sv
// Package for the seed sequence matcher: types, constants and the
// configuration register map used by the top, core and match modules. No dependencies.
package rssm_pkg;

   localparam int MaxSequence = 32;
   localparam int TwAddrWidth = 9;
   localparam int TwDepth = 512;
   localparam logic [8:0] TW_LAST = 9'd428;
   localparam logic [8:0] TW_M = 9'd397;

   localparam logic [31:0] TW_INIT_MULT = 32'h6C07_8965;
   localparam logic [31:0] TW_MATRIX = 32'h9908_B0DF;
   localparam logic [31:0] TW_TEMPER_B = 32'h9D2C_5680;
   localparam logic [31:0] TW_TEMPER_C = 32'hEFC6_0000;
   localparam logic [31:0] TW_UPPER = 32'h8000_0000;
   localparam logic [31:0] TW_LOWER = 32'h7FFF_FFFF;
   localparam logic [31:0] LCG_MULT = 32'h41C6_4E6D;
   localparam logic [31:0] LCG_ADD = 32'h0000_6073;
   localparam logic [31:0] YEAR_BASE = 32'd2000;
   localparam logic [16:0] RECIP3 = 17'h0AAAB;

   typedef enum logic [2:0] {
      CSR_GAME_MODE = 3'd0,
      CSR_PATTERN_LOW = 3'd1,
      CSR_PATTERN_HIGH = 3'd2,
      CSR_PATTERN_LENGTH = 3'd3,
      CSR_SEQUENCE_LENGTH = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0] month;
      logic [4:0] day_of_month;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [19:0] delay;
   } req_type;

   typedef struct packed {
      logic [31:0] seed;
      logic matched;
      logic [31:0] sequence_low;
      logic [31:0] sequence_high;
   } rsp_type;

   typedef struct packed {
      logic game_mode;
      logic [63:0] pattern;
      logic [5:0] pattern_length;
      logic [5:0] sequence_length;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic [5:0] count;
      logic [63:0] sequence_bits;
   } match_ctrl_type;

   typedef struct packed {
      logic done;
      logic matched;
   } match_stat_type;

endpackage

>>> hw/rtl/rng_seed_sequence_matcher_top.sv
// Top level of the seed sequence matcher: ports, configuration registers
// and the result register. Depends on rssm_pkg and rssm_core.

// Each transaction is one candidate. The block forms its seed and draws
// up to 32 values. In twister mode a serial initialization multiply chain
// first fills the word RAM, and each draw then needs two RAM reads. In
// LCG mode each draw takes a multiply step and a modulo step. A finished
// result waits in an output register, so the next candidate may be
// accepted while it is still waiting.
module rng_seed_sequence_matcher_top
   import rssm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   cfg_type cfg_ff;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic core_idle;
   logic res_valid;
   logic res_take;
   rsp_type res;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.game_mode <= 1'b0;
         cfg_ff.pattern <= 64'd0;
         cfg_ff.pattern_length <= 6'd0;
         cfg_ff.sequence_length <= 6'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_GAME_MODE: cfg_ff.game_mode <= csr_data[0];
            CSR_PATTERN_LOW: cfg_ff.pattern[31:0] <= csr_data;
            CSR_PATTERN_HIGH: cfg_ff.pattern[63:32] <= csr_data;
            CSR_PATTERN_LENGTH: cfg_ff.pattern_length <= csr_data[5:0];
            CSR_SEQUENCE_LENGTH: cfg_ff.sequence_length <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   assign req_ready = core_idle;
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   rssm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .start     (req_valid && req_ready),
      .req       (req_data),
      .idle      (core_idle),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_take) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // Checks across the core and the output register.
   a_take_when_free: assert property (@(posedge clock) disable iff (reset)
      res_take |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrote a pending transaction");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !core_idle)
      else $error("core stayed idle after accepting a transaction");
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      res_take |=> rsp_valid_ff)
      else $error("taken result not presented");

endmodule

>>> hw/rtl/rssm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module rssm_ram #(
   parameter int Width = 32,
   parameter int Depth = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/rssm_match.sv
// Window compare of the drawn sequence against the configured pattern,
// one start position per cycle. Depends on rssm_pkg.
module rssm_match
   import rssm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  match_ctrl_type ctrl,
   output match_stat_type stat
);

   logic busy_ff;
   logic done_ff;
   logic matched_ff;
   logic [63:0] win_ff;
   logic [63:0] mask_ff;
   logic [5:0] left_ff;
   logic hit;
   logic [6:0] shift_amt;

   assign hit = ((win_ff ^ cfg.pattern) & mask_ff) == 64'd0;
   assign shift_amt = 7'd64 - {cfg.pattern_length, 1'b0};

   // One window per cycle until a hit or the last start position.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         matched_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            win_ff <= ctrl.sequence_bits;
            mask_ff <= {64{1'b1}} >> shift_amt;
            left_ff <= ctrl.count - cfg.pattern_length;
            if (cfg.pattern_length == 6'd0) begin
               done_ff <= 1'b1;
               matched_ff <= 1'b1;
            end else if (cfg.pattern_length > ctrl.count) begin
               done_ff <= 1'b1;
               matched_ff <= 1'b0;
            end else begin
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            if (hit || left_ff == 6'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               matched_ff <= hit;
            end else begin
               win_ff <= win_ff >> 2;
               left_ff <= left_ff - 6'd1;
            end
         end
      end
   end

   assign stat.done = done_ff;
   assign stat.matched = matched_ff;

   // Checks on the compare sequencer.
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff || $past(ctrl.start))
      else $error("match done held for more than one cycle");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !ctrl.start)
      else $error("match started while busy");
   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> left_ff <= 6'd32)
      else $error("window count out of range");

endmodule

>>> hw/rtl/rssm_core.sv
// Seed formation, generator sequencing around the twister word RAM and the
// LCG, and packing of drawn values. Depends on rssm_pkg, rssm_ram, rssm_match.
module rssm_core
   import rssm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    start,
   input  req_type req,
   output logic    idle,
   output logic    res_valid,
   input  logic    res_take,
   output rsp_type res
);

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_RD1, S_RD2, S_CALC, S_LMUL, S_LMOD, S_MATCH, S_MWAIT, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] seed_ff, seed_in;
   logic [31:0] p_ff, p_in;
   logic [31:0] cur_ff, cur_in;
   logic [31:0] nxt_ff, nxt_in;
   logic [8:0] i_ff, i_in;
   logic [5:0] k_ff, k_in;
   logic [5:0] count_ff, count_in;
   logic [63:0] seq_ff, seq_in;
   logic matched_ff, matched_in;

   logic [7:0] ab;
   logic [31:0] seed_calc;
   logic [5:0] count_calc;
   logic [31:0] p_mix, p_next;
   logic [31:0] ram_rdata;
   logic ram_we;
   logic [TwAddrWidth-1:0] ram_raddr;
   logic [31:0] y, tw, t1, t2, t3, t4;
   logic [15:0] hi16;
   logic [32:0] q_prod;
   logic [15:0] q;
   logic [17:0] q3;
   logic [1:0] lcg_v;
   logic [1:0] draw_v;
   logic last_draw;
   match_ctrl_type mctrl;
   match_stat_type mstat;

   // Seed from date, time and delay.
   assign ab = 8'(8'(req.month) * 8'(req.day_of_month) + 8'(req.minute) + 8'(req.second));
   assign seed_calc = {ab, 3'b000, req.hour, 16'h0000} + 32'(req.delay)
                      + 32'(req.year) - YEAR_BASE;
   assign count_calc = (cfg.sequence_length > 6'(MaxSequence)) ? 6'(MaxSequence)
                                                               : cfg.sequence_length;

   // Twister initialization step and twist/temper of one word.
   assign p_mix = p_ff ^ (p_ff >> 30);
   assign p_next = 32'(TW_INIT_MULT * p_mix) + 32'(i_ff);
   assign y = (cur_ff & TW_UPPER) | (nxt_ff & TW_LOWER);
   assign tw = ram_rdata ^ (y >> 1) ^ (y[0] ? TW_MATRIX : 32'd0);
   assign t1 = tw ^ (tw >> 11);
   assign t2 = t1 ^ ((t1 << 7) & TW_TEMPER_B);
   assign t3 = t2 ^ ((t2 << 15) & TW_TEMPER_C);
   assign t4 = t3 ^ (t3 >> 18);

   // LCG value: upper half mod 3 by reciprocal multiply.
   assign hi16 = p_ff[31:16];
   assign q_prod = 33'(hi16) * 33'(RECIP3);
   assign q = 16'(q_prod >> 17);
   assign q3 = 18'(q) * 18'd3;
   assign lcg_v = 2'(18'(hi16) - q3);

   assign draw_v = (state_ff == S_CALC) ? {1'b0, t4[0]} : lcg_v;
   assign last_draw = (k_ff + 6'd1) == count_ff;

   // RAM port use by state.
   assign ram_we = (state_ff == S_INIT);
   always_comb begin
      if (state_ff == S_RD1) begin
         ram_raddr = 9'(k_ff) + 9'd1;
      end else begin
         ram_raddr = 9'(k_ff) + TW_M;
      end
   end

   rssm_ram #(.Width(32), .Depth(TwDepth)) u_words (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (i_ff),
      .wr_data (p_next),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign mctrl.start = (state_ff == S_MATCH);
   assign mctrl.count = count_ff;
   assign mctrl.sequence_bits = seq_ff;

   rssm_match u_match (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .ctrl  (mctrl),
      .stat  (mstat)
   );

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      seed_in = seed_ff;
      p_in = p_ff;
      cur_in = cur_ff;
      nxt_in = nxt_ff;
      i_in = i_ff;
      k_in = k_ff;
      count_in = count_ff;
      seq_in = seq_ff;
      matched_in = matched_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               seed_in = seed_calc;
               p_in = seed_calc;
               cur_in = seed_calc;
               i_in = 9'd1;
               k_in = 6'd0;
               count_in = count_calc;
               seq_in = 64'd0;
               if (count_calc == 6'd0) begin
                  state_in = S_MATCH;
               end else if (!cfg.game_mode) begin
                  state_in = S_INIT;
               end else begin
                  state_in = S_LMUL;
               end
            end
         end
         S_INIT: begin
            p_in = p_next;
            i_in = i_ff + 9'd1;
            if (i_ff == TW_LAST) begin
               state_in = S_RD1;
            end
         end
         S_RD1: state_in = S_RD2;
         S_RD2: begin
            nxt_in = ram_rdata;
            state_in = S_CALC;
         end
         S_CALC: begin
            seq_in[{k_ff[4:0], 1'b0} +: 2] = draw_v;
            cur_in = nxt_ff;
            k_in = k_ff + 6'd1;
            state_in = last_draw ? S_MATCH : S_RD1;
         end
         S_LMUL: begin
            p_in = 32'(p_ff * LCG_MULT) + LCG_ADD;
            state_in = S_LMOD;
         end
         S_LMOD: begin
            seq_in[{k_ff[4:0], 1'b0} +: 2] = draw_v;
            k_in = k_ff + 6'd1;
            state_in = last_draw ? S_MATCH : S_LMUL;
         end
         S_MATCH: state_in = S_MWAIT;
         S_MWAIT: begin
            if (mstat.done) begin
               matched_in = mstat.matched;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      seed_ff <= seed_in;
      p_ff <= p_in;
      cur_ff <= cur_in;
      nxt_ff <= nxt_in;
      i_ff <= i_in;
      k_ff <= k_in;
      count_ff <= count_in;
      seq_ff <= seq_in;
      matched_ff <= matched_in;
   end

   assign idle = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res.seed = seed_ff;
   assign res.matched = matched_ff;
   assign res.sequence_low = seq_ff[31:0];
   assign res.sequence_high = seq_ff[63:32];

   // Checks on the sequencer.
   a_calc_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CALC |-> $past(state_ff) == S_RD2)
      else $error("twist step without both word reads");
   a_draw_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CALC || state_ff == S_LMOD) |-> k_ff < count_ff)
      else $error("draw index beyond sequence length");
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !res_take) |=> state_ff == S_DONE)
      else $error("result dropped before it was taken");

endmodule
